// ===== rtl/abee_pkg.sv =====
// Shared types, character codes and decode functions for the expression evaluator.
`timescale 1ns / 1ps
package abee_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam int         DEC_RADIX  = 10;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_PARSE = 2'd1,
        STAT_DIV0  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_SIGN1   = 4'd1,
        PH_DIGITS1 = 4'd2,
        PH_BLANK1  = 4'd3,
        PH_OPER    = 4'd4,
        PH_SIGN2   = 4'd5,
        PH_DIGITS2 = 4'd6,
        PH_BLANK2  = 4'd7
    } phase_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_NEG_A,
        SEQ_NEG_B,
        SEQ_ABS_A,
        SEQ_ABS_B,
        SEQ_ADD,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_SIGN,
        SEQ_DONE
    } seq_t;

    typedef struct packed {
        logic hit;
        op_t  code;
    } op_dec_t;

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic op_dec_t op_of(input logic [7:0] c);
        op_dec_t d;
        d.hit  = 1'b1;
        d.code = OP_ADD;
        case (c)
            CH_PLUS:    d.code = OP_ADD;
            CH_MINUS:   d.code = OP_SUB;
            CH_STAR:    d.code = OP_MUL;
            CH_SLASH:   d.code = OP_DIV;
            CH_PERCENT: d.code = OP_REM;
            default:    d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    // Append one decimal digit, wrapping to the word width.
    function automatic logic [WORD_W-1:0] acc_digit(input logic [WORD_W-1:0] v,
                                                   input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return WORD_W'(v * WORD_W'(DEC_RADIX)) + WORD_W'(d[3:0]);
    endfunction

endpackage

// ===== rtl/abee_if.sv =====
// Valid/ready channel interfaces for line characters and results.
`timescale 1ns / 1ps
interface abee_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       line_end;

    modport source (output valid, output character, output line_end, input ready);
    modport sink   (input valid, input character, input line_end, output ready);
endinterface

interface abee_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_value;

    modport source (output valid, output status, output result_value, input ready);
    modport sink   (input valid, input status, input result_value, output ready);
endinterface

// ===== rtl/ascii_binary_expression_evaluator.sv =====
// Top level: line parser and sequenced arithmetic for "number operator number" text.
`timescale 1ns / 1ps
// Usage
//   chars   : one transaction per byte of the line. line_end = 1 marks the end of the
//             line (its character is ignored). A zero byte ends the text early.
//   results : one transaction per line end: status (0 ok, 1 parse error, 2 divide by
//             zero) and the wrapped 32-bit result, zero unless status is ok.
// Sequencing
//   Ordinary characters leave chars.ready high; only a line end takes the block out of idle.
//   A line end occupies the block while one shared 32-bit add/subtract unit is stepped:
//   a parse error goes straight to the result step; + and - take the two negations and
//   an add; * takes the negations and one shift-add per bit; / and % take two
//   negations, two magnitude steps, 32 restoring divide steps and one sign fix-up;
//   a zero divisor stops after the negations.
// Reset
//   rst_n clears the parser to "before first number", empties the result register
//   and returns the sequencer to idle; the block takes characters straight away.
// Stalls
//   A finished result sits in the output register until results.ready; characters of
//   the next line are still taken meanwhile. A second line end waits in its final
//   step until the register is free.
module ascii_binary_expression_evaluator
    import abee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    abee_char_if.sink            chars,
    abee_result_if.source        results
);

    // Parser state
    phase_t              phase_reg,    phase_next;
    logic [WORD_W-1:0]   left_reg,     left_next;
    logic                left_neg_reg, left_neg_next;
    op_t                 op_reg,       op_next;
    logic [WORD_W-1:0]   right_reg,    right_next;
    logic                right_neg_reg, right_neg_next;
    logic                err_reg,      err_next;
    logic                ended_reg,    ended_next;

    // Sequencer and datapath
    seq_t                seq_reg,      seq_next;
    op_t                 calc_op_reg,  calc_op_next;
    logic [WORD_W-1:0]   opa_reg,      opa_next;
    logic [WORD_W-1:0]   opb_reg,      opb_next;
    logic [WORD_W-1:0]   work_reg,     work_next;
    logic                a_neg_reg,    a_neg_next;
    logic                b_neg_reg,    b_neg_next;
    logic [CNT_W-1:0]    cnt_reg,      cnt_next;
    status_t             stat_reg,     stat_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    status_t             out_stat_reg,  out_stat_next;
    logic [WORD_W-1:0]   out_value_reg, out_value_next;

    // Shared add/subtract unit
    logic [WORD_W-1:0]   unit_x;
    logic [WORD_W-1:0]   unit_y;
    logic                unit_sub;
    logic [WORD_W:0]     unit_sum;

    logic                take;
    logic                take_char;
    logic                take_end;
    logic                out_free;
    op_dec_t             dec;
    logic [WORD_W-1:0]   sign_sel;
    logic                sign_neg;
    logic [WORD_W-1:0]   div_shift;

    assign chars.ready          = (seq_reg == SEQ_IDLE);
    assign take                 = chars.valid && chars.ready;
    assign take_char            = take && !chars.line_end;
    assign take_end             = take && chars.line_end;
    assign out_free             = !out_valid_reg || results.ready;
    assign dec                  = op_of(chars.character);

    assign results.valid        = out_valid_reg;
    assign results.status       = out_stat_reg;
    assign results.result_value = out_value_reg;

    // Dividend bit shifted into the partial remainder
    assign div_shift = {work_reg[WORD_W-2:0], opa_reg[WORD_W-1]};
    assign sign_sel  = (calc_op_reg == OP_DIV) ? opa_reg : work_reg;
    assign sign_neg  = (calc_op_reg == OP_DIV) ? (a_neg_reg ^ b_neg_reg) : a_neg_reg;

    always_comb
    begin
        unit_x   = '0;
        unit_y   = '0;
        unit_sub = 1'b0;
        unique case (seq_reg) inside
            SEQ_NEG_A, SEQ_ABS_A:
            begin
                unit_y   = opa_reg;
                unit_sub = 1'b1;
            end
            SEQ_NEG_B, SEQ_ABS_B:
            begin
                unit_y   = opb_reg;
                unit_sub = 1'b1;
            end
            SEQ_ADD:
            begin
                unit_x   = opa_reg;
                unit_y   = opb_reg;
                unit_sub = (calc_op_reg == OP_SUB);
            end
            SEQ_MUL:
            begin
                unit_x = work_reg;
                unit_y = opa_reg;
            end
            SEQ_DIV:
            begin
                unit_x   = div_shift;
                unit_y   = opb_reg;
                unit_sub = 1'b1;
            end
            SEQ_SIGN:
            begin
                unit_y   = sign_sel;
                unit_sub = 1'b1;
            end
            default:
            begin
                unit_sub = 1'b0;
            end
        endcase
        // Carry out high on subtract means no borrow
        unit_sum = {1'b0, unit_x} + {1'b0, (unit_sub ? ~unit_y : unit_y)}
                   + (WORD_W + 1)'(unit_sub);
    end

    // Character parser
    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        left_neg_next  = left_neg_reg;
        op_next        = op_reg;
        right_next     = right_reg;
        right_neg_next = right_neg_reg;
        err_next       = err_reg;
        ended_next     = ended_reg;

        if (take_end)
        begin
            // Start over for the next line
            phase_next     = PH_START;
            left_next      = '0;
            left_neg_next  = 1'b0;
            op_next        = OP_ADD;
            right_next     = '0;
            right_neg_next = 1'b0;
            err_next       = 1'b0;
            ended_next     = 1'b0;
        end
        else if (take_char && !ended_reg && !err_reg)
        begin
            if (chars.character == CH_NUL)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                err_next = 1'b1;
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (is_blank(chars.character))
                        begin
                            err_next = 1'b0;
                        end
                        else if (is_sign(chars.character))
                        begin
                            err_next      = 1'b0;
                            left_neg_next = (chars.character == CH_MINUS);
                            phase_next    = PH_SIGN1;
                        end
                        else if (is_numeral(chars.character))
                        begin
                            err_next   = 1'b0;
                            left_next  = acc_digit(left_reg, chars.character);
                            phase_next = PH_DIGITS1;
                        end
                    end
                    PH_SIGN1:
                    begin
                        if (is_numeral(chars.character))
                        begin
                            err_next   = 1'b0;
                            left_next  = acc_digit(left_reg, chars.character);
                            phase_next = PH_DIGITS1;
                        end
                    end
                    PH_DIGITS1:
                    begin
                        if (is_numeral(chars.character))
                        begin
                            err_next  = 1'b0;
                            left_next = acc_digit(left_reg, chars.character);
                        end
                        else if (is_blank(chars.character))
                        begin
                            err_next   = 1'b0;
                            phase_next = PH_BLANK1;
                        end
                        else if (dec.hit)
                        begin
                            err_next   = 1'b0;
                            op_next    = dec.code;
                            phase_next = PH_OPER;
                        end
                    end
                    PH_BLANK1:
                    begin
                        if (is_blank(chars.character))
                        begin
                            err_next = 1'b0;
                        end
                        else if (dec.hit)
                        begin
                            err_next   = 1'b0;
                            op_next    = dec.code;
                            phase_next = PH_OPER;
                        end
                    end
                    PH_OPER:
                    begin
                        if (is_blank(chars.character))
                        begin
                            err_next = 1'b0;
                        end
                        else if (is_sign(chars.character))
                        begin
                            err_next       = 1'b0;
                            right_neg_next = (chars.character == CH_MINUS);
                            phase_next     = PH_SIGN2;
                        end
                        else if (is_numeral(chars.character))
                        begin
                            err_next   = 1'b0;
                            right_next = acc_digit(right_reg, chars.character);
                            phase_next = PH_DIGITS2;
                        end
                    end
                    PH_SIGN2:
                    begin
                        if (is_numeral(chars.character))
                        begin
                            err_next   = 1'b0;
                            right_next = acc_digit(right_reg, chars.character);
                            phase_next = PH_DIGITS2;
                        end
                    end
                    PH_DIGITS2:
                    begin
                        if (is_numeral(chars.character))
                        begin
                            err_next   = 1'b0;
                            right_next = acc_digit(right_reg, chars.character);
                        end
                        else if (is_blank(chars.character))
                        begin
                            err_next   = 1'b0;
                            phase_next = PH_BLANK2;
                        end
                    end
                    PH_BLANK2:
                    begin
                        if (is_blank(chars.character))
                        begin
                            err_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // Sequencer: next state and datapath
    always_comb
    begin
        seq_next       = seq_reg;
        calc_op_next   = calc_op_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        work_next      = work_reg;
        a_neg_next     = a_neg_reg;
        b_neg_next     = b_neg_reg;
        cnt_next       = cnt_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_stat_next  = out_stat_reg;
        out_value_next = out_value_reg;

        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (take_end)
                begin
                    calc_op_next = op_reg;
                    opa_next     = left_reg;
                    opb_next     = right_reg;
                    a_neg_next   = left_neg_reg;
                    b_neg_next   = right_neg_reg;
                    if (err_reg || (phase_reg != PH_DIGITS2 && phase_reg != PH_BLANK2))
                    begin
                        stat_next = STAT_PARSE;
                        work_next = '0;
                        seq_next  = SEQ_DONE;
                    end
                    else
                    begin
                        stat_next = STAT_OK;
                        seq_next  = SEQ_NEG_A;
                    end
                end
            end
            SEQ_NEG_A:
            begin
                if (a_neg_reg)
                begin
                    opa_next = unit_sum[WORD_W-1:0];
                end
                seq_next = SEQ_NEG_B;
            end
            SEQ_NEG_B:
            begin
                if (b_neg_reg)
                begin
                    opb_next = unit_sum[WORD_W-1:0];
                end
                work_next = '0;
                cnt_next  = '0;
                unique case (calc_op_reg) inside
                    OP_ADD, OP_SUB:
                    begin
                        seq_next = SEQ_ADD;
                    end
                    OP_MUL:
                    begin
                        seq_next = SEQ_MUL;
                    end
                    default:
                    begin
                        // Zero magnitude stays zero whatever the sign
                        if (opb_reg == '0)
                        begin
                            stat_next = STAT_DIV0;
                            seq_next  = SEQ_DONE;
                        end
                        else
                        begin
                            seq_next = SEQ_ABS_A;
                        end
                    end
                endcase
            end
            SEQ_ABS_A:
            begin
                a_neg_next = opa_reg[WORD_W-1];
                if (opa_reg[WORD_W-1])
                begin
                    opa_next = unit_sum[WORD_W-1:0];
                end
                seq_next = SEQ_ABS_B;
            end
            SEQ_ABS_B:
            begin
                b_neg_next = opb_reg[WORD_W-1];
                if (opb_reg[WORD_W-1])
                begin
                    opb_next = unit_sum[WORD_W-1:0];
                end
                seq_next = SEQ_DIV;
            end
            SEQ_ADD:
            begin
                work_next = unit_sum[WORD_W-1:0];
                seq_next  = SEQ_DONE;
            end
            SEQ_MUL:
            begin
                if (opb_reg[0])
                begin
                    work_next = unit_sum[WORD_W-1:0];
                end
                opa_next = {opa_reg[WORD_W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[WORD_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    seq_next = SEQ_DONE;
                end
            end
            SEQ_DIV:
            begin
                // Restoring step: quotient bit is the no-borrow flag
                work_next = unit_sum[WORD_W] ? unit_sum[WORD_W-1:0] : div_shift;
                opa_next  = {opa_reg[WORD_W-2:0], unit_sum[WORD_W]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    seq_next = SEQ_SIGN;
                end
            end
            SEQ_SIGN:
            begin
                work_next = sign_neg ? unit_sum[WORD_W-1:0] : sign_sel;
                seq_next  = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_value_next = (stat_reg == STAT_OK) ? work_reg : '0;
                    seq_next       = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            left_reg      <= '0;
            left_neg_reg  <= 1'b0;
            op_reg        <= OP_ADD;
            right_reg     <= '0;
            right_neg_reg <= 1'b0;
            err_reg       <= 1'b0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            left_neg_reg  <= left_neg_next;
            op_reg        <= op_next;
            right_reg     <= right_next;
            right_neg_reg <= right_neg_next;
            err_reg       <= err_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        calc_op_reg   <= calc_op_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        work_reg      <= work_next;
        a_neg_reg     <= a_neg_next;
        b_neg_reg     <= b_neg_next;
        cnt_reg       <= cnt_next;
        stat_reg      <= stat_next;
        out_stat_reg  <= out_stat_next;
        out_value_reg <= out_value_next;
    end

    // A line end always leaves the parser clean for the next line
    assert property (@(posedge clk) disable iff (!rst_n)
        take_end |=> (phase_reg == PH_START) && !err_reg && !ended_reg
                     && (left_reg == '0) && (right_reg == '0))
        else $error("parser not cleared after line end");

    // The divide loop keeps advancing one bit per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_DIV) && (cnt_reg != CNT_LAST)
        |=> (seq_reg == SEQ_DIV) && (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("divide loop stalled or left early");

    // Remainder ends below the divisor magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_DIV) && (cnt_reg == CNT_LAST) |=> (work_reg < opb_reg))
        else $error("remainder not below divisor");

    // A failed line never reports a value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_stat_reg != STAT_OK) |-> (out_value_reg == '0))
        else $error("non-zero value with error status");

    // A pending result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(out_value_reg)
                                            && $stable(out_stat_reg))
        else $error("pending result overwritten");

endmodule
